FILE: src/random_dfs_maze_carver_unit_defines.svh
// assertion macros for the maze carver block
// used by the top level, no other dependencies
`ifndef RANDOM_DFS_MAZE_CARVER_UNIT_DEFINES_SVH
`define RANDOM_DFS_MAZE_CARVER_UNIT_DEFINES_SVH

// same-cycle implication
`define RDMC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RDMC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/rdmc_pkg.sv
// shared constants, types and helper functions of the maze carver
// no dependencies
`timescale 1ns / 1ps

package rdmc_pkg;

   localparam int MAX_DIM       = 127;
   localparam int MAX_CELLS     = 4096;
   localparam int RAND_TOP      = 32767;

   localparam int COORD_W       = 7;
   localparam int DEPTH_W       = 13;
   localparam int RAND_W        = 15;
   localparam int KIND_W        = 2;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 7;
   localparam int CELLS_PER_ROW = (MAX_DIM + 1) / 2;
   localparam int HALF_W        = $clog2(CELLS_PER_ROW);
   localparam int CELL_IDX_W    = $clog2(MAX_CELLS);

   localparam logic OP_ADVANCE = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   localparam logic [KIND_W-1:0] KIND_CARVE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BACK    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;
   localparam logic [KIND_W-1:0] KIND_IDLE    = 2'd3;

   localparam logic [1:0] DIR_LEFT  = 2'd0;
   localparam logic [1:0] DIR_UP    = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] REG_GRID_ROWS    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_GRID_COLUMNS = 1'b1;

   localparam logic [COORD_W-1:0] GRID_RESET = 7'd63;

   localparam logic [31:0] THR2_1 = 32'(RAND_TOP / 2 + 1);
   localparam logic [31:0] THR3_1 = 32'(RAND_TOP / 3 + 1);
   localparam logic [31:0] THR3_2 = 32'(2 * (RAND_TOP / 3 + 1));
   localparam logic [31:0] THR4_1 = 32'(RAND_TOP / 4 + 1);
   localparam logic [31:0] THR4_2 = 32'(2 * (RAND_TOP / 4 + 1));
   localparam logic [31:0] THR4_3 = 32'(3 * (RAND_TOP / 4 + 1));

   typedef struct packed {
      logic [HALF_W-1:0]  cur_row;
      logic [HALF_W-1:0]  cur_col;
      logic [1:0]         dir;
      logic [COORD_W-1:0] rows;
      logic [COORD_W-1:0] cols;
   } nbr_query_type;

   typedef struct packed {
      logic                  ok;
      logic [CELL_IDX_W-1:0] idx;
      logic [COORD_W-1:0]    wall_row;
      logic [COORD_W-1:0]    wall_col;
   } nbr_result_type;

   function automatic logic [COORD_W-1:0] eff_dim(input logic [COORD_W-1:0] v);
      logic [COORD_W-1:0] t;
      t = v;
      if (t == '0) t = COORD_W'(1);
      if (int'(t) > MAX_DIM) t = COORD_W'(MAX_DIM);
      if (!t[0]) t = t - 1'b1;
      return t;
   endfunction

   // move number among n candidates
   function automatic logic [1:0] pick_index(input logic [2:0] n,
                                             input logic [RAND_W-1:0] rnd);
      logic [31:0] r;
      logic [1:0]  p;
      r = 32'(rnd);
      p = 2'd0;
      case (n)
         3'd2: begin
            if (r >= THR2_1) p = 2'd1;
         end
         3'd3: begin
            if (r >= THR3_2) p = 2'd2;
            else if (r >= THR3_1) p = 2'd1;
         end
         3'd4: begin
            if (r >= THR4_3) p = 2'd3;
            else if (r >= THR4_2) p = 2'd2;
            else if (r >= THR4_1) p = 2'd1;
         end
         default: p = 2'd0;
      endcase
      return p;
   endfunction

   // direction of the p-th set bit of the move mask
   function automatic logic [1:0] sel_move(input logic [3:0] mask, input logic [1:0] p);
      logic [1:0] d;
      logic [2:0] cnt;
      d = DIR_LEFT;
      cnt = 3'd0;
      for (int i = 0; i < 4; i++) begin
         if (mask[i]) begin
            if (cnt == {1'b0, p}) d = 2'(i);
            cnt = cnt + 3'd1;
         end
      end
      return d;
   endfunction

endpackage

FILE: src/rdmc_if.sv
// request and response channel interfaces of the maze carver
// depends on rdmc_pkg
`timescale 1ns / 1ps

interface rdmc_req_if;
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic [rdmc_pkg::RAND_W-1:0]  random_value;

   modport source (output valid, output op, output random_value, input ready);
   modport sink (input valid, input op, input random_value, output ready);
endinterface

interface rdmc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rdmc_pkg::KIND_W-1:0]   kind;
   logic [rdmc_pkg::COORD_W-1:0]  wall_col;
   logic [rdmc_pkg::COORD_W-1:0]  wall_row;
   logic [rdmc_pkg::COORD_W-1:0]  cell_col;
   logic [rdmc_pkg::COORD_W-1:0]  cell_row;
   logic [rdmc_pkg::DEPTH_W-1:0]  depth;
   logic                          finished;

   modport source (output valid, output kind, output wall_col, output wall_row,
                   output cell_col, output cell_row, output depth, output finished,
                   input ready);
   modport sink (input valid, input kind, input wall_col, input wall_row,
                 input cell_col, input cell_row, input depth, input finished,
                 output ready);
endinterface

FILE: src/rdmc_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module rdmc_ram #(
   parameter int DATA_W = 1,
   parameter int DEPTH  = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DATA_W-1:0]        wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/rdmc_nbr_unit.sv
// shared neighbor unit: bounds check, neighbor cell index and wall position
// depends on rdmc_pkg
`timescale 1ns / 1ps

module rdmc_nbr_unit (
   input  rdmc_pkg::nbr_query_type  query,
   output rdmc_pkg::nbr_result_type result
);

   localparam int HW  = rdmc_pkg::HALF_W;
   localparam int CW  = rdmc_pkg::COORD_W;
   localparam int IW  = rdmc_pkg::CELL_IDX_W;
   localparam int FW  = 2 * HW + 1;

   logic [CW-1:0] cr;
   logic [CW-1:0] cc;
   logic [HW-1:0] row_n;
   logic [HW-1:0] col_n;
   logic [CW-1:0] wall_r;
   logic [CW-1:0] wall_c;
   logic          in_bounds;
   logic [FW-1:0] idx_full;

   assign cr = CW'({query.cur_row, 1'b0});
   assign cc = CW'({query.cur_col, 1'b0});

   always_comb begin
      row_n     = query.cur_row;
      col_n     = query.cur_col;
      wall_r    = cr;
      wall_c    = cc;
      in_bounds = 1'b0;
      case (query.dir)
         rdmc_pkg::DIR_LEFT: begin
            in_bounds = (cc != '0);
            col_n     = query.cur_col - 1'b1;
            wall_c    = cc - 1'b1;
         end
         rdmc_pkg::DIR_UP: begin
            in_bounds = (cr != '0);
            row_n     = query.cur_row - 1'b1;
            wall_r    = cr - 1'b1;
         end
         rdmc_pkg::DIR_DOWN: begin
            in_bounds = ((CW+1)'(cr) + 1'b1) < (CW+1)'(query.rows);
            row_n     = query.cur_row + 1'b1;
            wall_r    = cr + 1'b1;
         end
         rdmc_pkg::DIR_RIGHT: begin
            in_bounds = ((CW+1)'(cc) + 1'b1) < (CW+1)'(query.cols);
            col_n     = query.cur_col + 1'b1;
            wall_c    = cc + 1'b1;
         end
         default: in_bounds = 1'b0;
      endcase
   end

   assign idx_full = FW'(FW'(row_n) * FW'(rdmc_pkg::CELLS_PER_ROW) + FW'(col_n));

   // an index past the map counts as visited
   assign result.ok       = in_bounds && (int'(idx_full) < rdmc_pkg::MAX_CELLS);
   assign result.idx      = IW'(idx_full);
   assign result.wall_row = wall_r;
   assign result.wall_col = wall_c;

endmodule

FILE: src/random_dfs_maze_carver_unit.sv
// top level of the randomized depth-first maze carver: sequencer, map and stack
// depends on rdmc_pkg, rdmc_if, rdmc_ram, rdmc_nbr_unit and the defines header
//
//   channel  dir   handshake       payload
//   req      in    valid / ready   op, random_value
//   rsp      out   valid / ready   kind, wall_col, wall_row, cell_col, cell_row, depth, finished
//   csr      in    csr_we          csr_index, csr_wdata
//
// advance: a carved wall, a backtrack or a finished item; the visited
//   map has one read port, so the four neighbors are read one per cycle
// restart: the visited map is cleared one entry per cycle
// reset needs no clearing pass; the map is only read after a restart has cleared it
// ready is high only between items; a result waits in the output register for rsp ready
`timescale 1ns / 1ps
`include "random_dfs_maze_carver_unit_defines.svh"

module random_dfs_maze_carver_unit (
   input  logic                                clock,
   input  logic                                reset,
   rdmc_req_if.sink                            req_chan,
   rdmc_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [rdmc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rdmc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int HW = rdmc_pkg::HALF_W;
   localparam int CW = rdmc_pkg::COORD_W;
   localparam int IW = rdmc_pkg::CELL_IDX_W;
   localparam int DW = rdmc_pkg::DEPTH_W;
   localparam int RW = rdmc_pkg::RAND_W;
   localparam int KW = rdmc_pkg::KIND_W;
   localparam logic [2:0] DIR_COUNT = 3'd4;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_CLEAR    = 7'b0000010,
      S_INIT     = 7'b0000100,
      S_SCAN     = 7'b0001000,
      S_DECIDE   = 7'b0010000,
      S_POP_WAIT = 7'b0100000,
      S_EMIT     = 7'b1000000
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] rows_ff, cols_ff;
   logic [RW-1:0] rnd_ff, rnd_in;
   logic          active_ff, active_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [IW-1:0] top_ff, top_in;
   logic [3:0]    mask_ff, mask_in;
   logic [2:0]    dir_ff, dir_in;
   logic          ok_pipe_ff, ok_pipe_in;
   logic [IW-1:0] clr_addr_ff, clr_addr_in;
   logic [KW-1:0] kind_ff, kind_in;
   logic [CW-1:0] wall_row_ff, wall_row_in;
   logic [CW-1:0] wall_col_ff, wall_col_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [KW-1:0] rsp_kind_ff;
   logic [CW-1:0] rsp_wall_col_ff, rsp_wall_row_ff;
   logic [CW-1:0] rsp_cell_col_ff, rsp_cell_row_ff;
   logic [DW-1:0] rsp_depth_ff;
   logic          rsp_finished_ff;
   logic          rsp_load;

   logic          req_accept;
   logic          vis_we, vis_wdata, vis_rdata;
   logic [IW-1:0] vis_waddr, vis_raddr;
   logic          stk_we;
   logic [IW-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;
   logic [DW-1:0] depth_m2;
   logic [2:0]    move_cnt;
   logic [1:0]    scan_slot;

   rdmc_pkg::nbr_query_type  nbr_query;
   rdmc_pkg::nbr_result_type nbr_result;

   rdmc_ram #(
      .DATA_W (1),
      .DEPTH  (rdmc_pkg::MAX_CELLS)
   ) u_visited (
      .clock (clock),
      .we    (vis_we),
      .waddr (vis_waddr),
      .wdata (vis_wdata),
      .raddr (vis_raddr),
      .rdata (vis_rdata)
   );

   rdmc_ram #(
      .DATA_W (rdmc_pkg::CELL_IDX_W),
      .DEPTH  (rdmc_pkg::MAX_CELLS)
   ) u_stack (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   rdmc_nbr_unit u_nbr (
      .query  (nbr_query),
      .result (nbr_result)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_load       = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_chan.ready);
   assign depth_m2       = depth_ff - DW'(2);
   assign move_cnt       = 3'($countones(mask_ff));
   assign scan_slot      = 2'(dir_ff - 3'd1);

   always_comb begin
      nbr_query.cur_row = HW'(top_ff / rdmc_pkg::CELLS_PER_ROW);
      nbr_query.cur_col = HW'(top_ff % rdmc_pkg::CELLS_PER_ROW);
      nbr_query.rows    = rdmc_pkg::eff_dim(rows_ff);
      nbr_query.cols    = rdmc_pkg::eff_dim(cols_ff);
      nbr_query.dir     = dir_ff[1:0];
      if (state_ff == S_DECIDE) begin
         nbr_query.dir = rdmc_pkg::sel_move(mask_ff, rdmc_pkg::pick_index(move_cnt, rnd_ff));
      end
   end

   always_comb begin
      state_in    = state_ff;
      rnd_in      = rnd_ff;
      active_in   = active_ff;
      depth_in    = depth_ff;
      top_in      = top_ff;
      mask_in     = mask_ff;
      dir_in      = dir_ff;
      ok_pipe_in  = ok_pipe_ff;
      clr_addr_in = clr_addr_ff;
      kind_in     = kind_ff;
      wall_row_in = wall_row_ff;
      wall_col_in = wall_col_ff;
      vis_we      = 1'b0;
      vis_waddr   = nbr_result.idx;
      vis_wdata   = 1'b0;
      vis_raddr   = nbr_result.idx;
      stk_we      = 1'b0;
      stk_waddr   = depth_ff[IW-1:0];
      stk_wdata   = nbr_result.idx;
      stk_raddr   = depth_m2[IW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               rnd_in = req_chan.random_value;
               if (req_chan.op == rdmc_pkg::OP_RESTART) begin
                  clr_addr_in = '0;
                  state_in    = S_CLEAR;
               end else if (!active_ff || depth_ff == '0 ||
                            int'(depth_ff) > rdmc_pkg::MAX_CELLS) begin
                  active_in   = 1'b0;
                  kind_in     = rdmc_pkg::KIND_IDLE;
                  wall_row_in = '0;
                  wall_col_in = '0;
                  state_in    = S_EMIT;
               end else begin
                  dir_in   = 3'd0;
                  mask_in  = 4'd0;
                  state_in = S_SCAN;
               end
            end
         end
         S_CLEAR: begin
            vis_we      = 1'b1;
            vis_waddr   = clr_addr_ff;
            vis_wdata   = 1'b0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == IW'(rdmc_pkg::MAX_CELLS - 1)) state_in = S_INIT;
         end
         S_INIT: begin
            vis_we      = 1'b1;
            vis_waddr   = '0;
            vis_wdata   = 1'b1;
            stk_we      = 1'b1;
            stk_waddr   = '0;
            stk_wdata   = '0;
            top_in      = '0;
            depth_in    = DW'(1);
            active_in   = 1'b1;
            kind_in     = rdmc_pkg::KIND_RESTART;
            wall_row_in = '0;
            wall_col_in = '0;
            state_in    = S_EMIT;
         end
         S_SCAN: begin
            // read neighbor dir_ff, judge the neighbor read in the previous cycle
            ok_pipe_in = nbr_result.ok;
            dir_in     = dir_ff + 3'd1;
            if (dir_ff != 3'd0) mask_in[scan_slot] = ok_pipe_ff && !vis_rdata;
            if (dir_ff == DIR_COUNT) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (move_cnt == 3'd0 || int'(depth_ff) >= rdmc_pkg::MAX_CELLS) begin
               depth_in    = depth_ff - 1'b1;
               active_in   = (depth_ff > DW'(2));
               kind_in     = rdmc_pkg::KIND_BACK;
               wall_row_in = '0;
               wall_col_in = '0;
               state_in    = S_POP_WAIT;
            end else begin
               vis_we      = 1'b1;
               vis_wdata   = 1'b1;
               stk_we      = 1'b1;
               top_in      = nbr_result.idx;
               depth_in    = depth_ff + 1'b1;
               active_in   = 1'b1;
               kind_in     = rdmc_pkg::KIND_CARVE;
               wall_row_in = nbr_result.wall_row;
               wall_col_in = nbr_result.wall_col;
               state_in    = S_EMIT;
            end
         end
         S_POP_WAIT: begin
            top_in   = stk_rdata;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= 1'b0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= rdmc_pkg::GRID_RESET;
         cols_ff      <= rdmc_pkg::GRID_RESET;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == rdmc_pkg::REG_GRID_ROWS) rows_ff <= csr_wdata;
         if (csr_we && csr_index == rdmc_pkg::REG_GRID_COLUMNS) cols_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rnd_in_reg: begin
         rnd_ff      <= rnd_in;
         top_ff      <= top_in;
         mask_ff     <= mask_in;
         dir_ff      <= dir_in;
         ok_pipe_ff  <= ok_pipe_in;
         clr_addr_ff <= clr_addr_in;
         kind_ff     <= kind_in;
         wall_row_ff <= wall_row_in;
         wall_col_ff <= wall_col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_kind_ff     <= kind_ff;
         rsp_wall_col_ff <= wall_col_ff;
         rsp_wall_row_ff <= wall_row_ff;
         rsp_depth_ff    <= depth_ff;
         rsp_finished_ff <= !active_ff;
         if (depth_ff != '0) begin
            rsp_cell_col_ff <= CW'({nbr_query.cur_col, 1'b0});
            rsp_cell_row_ff <= CW'({nbr_query.cur_row, 1'b0});
         end else begin
            rsp_cell_col_ff <= '0;
            rsp_cell_row_ff <= '0;
         end
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.kind     = rsp_kind_ff;
   assign rsp_chan.wall_col = rsp_wall_col_ff;
   assign rsp_chan.wall_row = rsp_wall_row_ff;
   assign rsp_chan.cell_col = rsp_cell_col_ff;
   assign rsp_chan.cell_row = rsp_cell_row_ff;
   assign rsp_chan.depth    = rsp_depth_ff;
   assign rsp_chan.finished = rsp_finished_ff;

   `RDMC_ASSERT_IMP(a_finished_depth, clock, reset, rsp_chan.valid && rsp_chan.finished, rsp_chan.depth <= DW'(1), "finished item with depth above one")
   `RDMC_ASSERT_IMP(a_restart_item, clock, reset, rsp_chan.valid && rsp_chan.kind == rdmc_pkg::KIND_RESTART, rsp_chan.depth == DW'(1) && !rsp_chan.finished && rsp_chan.cell_row == '0 && rsp_chan.cell_col == '0, "restart item with wrong stack top")
   `RDMC_ASSERT_NXT(a_busy_after_accept, clock, reset, req_accept, !req_chan.ready, "ready right after an accepted item")
   `RDMC_ASSERT_IMP(a_depth_bound, clock, reset, state_ff != S_IDLE, int'(depth_ff) <= rdmc_pkg::MAX_CELLS, "stack depth beyond the stack size")

endmodule
